[hdl/fna_pkg.sv]
// ----------------------------------------------------------------------------
// fna_pkg
// Shared types and constants of the four-neighbor autotiler: field widths,
// stream packing positions, register map and the flags passed between the
// position counter and the datapath.
// ----------------------------------------------------------------------------
package fna_pkg;

   // item field widths
   localparam int TILE_ID_W  = 16;
   localparam int NEW_TILE_W = 5;
   localparam int OUT_COL_W  = 10;
   localparam int OUT_ROW_W  = 12;

   // stream widths and packing
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int USER_PAD   = 0;
   localparam int USER_START = 1;

   // register port
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int ROW_WIDTH_W = 11;
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd64;

   // register index (byte address / 4)
   typedef enum logic [0:0] {
      CSR_ROW_WIDTH = 1'b0
   } fna_csr_index_type;

   // per-item position flags from the counter to the datapath
   typedef struct packed {
      logic first_col;  // column 0, left neighbor is outside the map
      logic right_ok;   // a column exists to the right in this row
      logic has_out;    // not the first row, a result is due
   } fna_flags_type;

endpackage

[hdl/fna_ram.sv]
// ----------------------------------------------------------------------------
// fna_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered, read returns the old data on a collision.
// ----------------------------------------------------------------------------
module fna_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/fna_csr.sv]
// ----------------------------------------------------------------------------
// fna_csr
// Register port: holds row_width, written and read over the APB-style port.
// ----------------------------------------------------------------------------
module fna_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fna_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [fna_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [fna_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [fna_pkg::ROW_WIDTH_W-1:0]  row_width
);
   import fna_pkg::*;

   logic [ROW_WIDTH_W-1:0] row_width_ff;
   logic [ROW_WIDTH_W-1:0] row_width_in;
   fna_csr_index_type      index;
   logic                   hit;

   // decode the word index
   assign index = fna_csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign hit   = (index == CSR_ROW_WIDTH);

   // write on the access phase
   always_comb begin
      row_width_in = row_width_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         row_width_in = csr_pwdata[ROW_WIDTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
      end else begin
         row_width_ff <= row_width_in;
      end
   end

   // read back
   assign csr_prdata = hit ? {{(CSR_DATA_W-ROW_WIDTH_W){1'b0}}, row_width_ff} : '0;
   assign csr_pready = 1'b1;
   assign row_width  = row_width_ff;

endmodule

[hdl/fna_index.sv]
// ----------------------------------------------------------------------------
// fna_index
// Raster position counter: clamps the row width, places each accepted item
// at its column and row, and produces the line store addresses and flags.
// ----------------------------------------------------------------------------
module fna_index #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_ROWS  = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                start_of_map,
   input  logic [fna_pkg::ROW_WIDTH_W-1:0]     row_width,
   output logic [$clog2(MAX_WIDTH)-1:0]        col,
   output logic [$clog2(MAX_WIDTH)-1:0]        right_addr,
   output logic [$clog2(MAX_ROWS)-1:0]         row,
   output fna_pkg::fna_flags_type              flags
);
   import fna_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int WW = (CW + 1 > ROW_WIDTH_W) ? CW + 1 : ROW_WIDTH_W;
   localparam logic [WW-1:0] W_MAX  = WW'(MAX_WIDTH);
   localparam logic [RW-1:0] ROW_TOP = RW'(MAX_ROWS - 1);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [WW-1:0] w_raw, w_eff;
   logic [CW-1:0] col0;
   logic [RW-1:0] row0, row_inc0;
   logic [RW-1:0] row_cur, row_inc1;
   logic [CW-1:0] col_cur;
   logic [WW-1:0] col_next;
   logic          wrap0, wrap1;

   // effective width, zero acts as one, clamp at the line store depth
   assign w_raw = {{(WW-ROW_WIDTH_W){1'b0}}, row_width};
   always_comb begin
      w_eff = w_raw;
      if (w_raw == '0) begin
         w_eff = WW'(1);
      end else if (w_raw > W_MAX) begin
         w_eff = W_MAX;
      end
   end

   // a start item restarts the map
   assign col0 = start_of_map ? '0 : col_ff;
   assign row0 = start_of_map ? '0 : row_ff;

   // column left over from a wider row starts a new row
   assign wrap0    = ({{(WW-CW){1'b0}}, col0} >= w_eff);
   assign row_inc0 = (row0 == ROW_TOP) ? row0 : row0 + RW'(1);
   assign col_cur  = wrap0 ? '0 : col0;
   assign row_cur  = wrap0 ? row_inc0 : row0;

   // advance past this item
   assign col_next = {{(WW-CW){1'b0}}, col_cur} + WW'(1);
   assign wrap1    = (col_next >= w_eff);
   assign row_inc1 = (row_cur == ROW_TOP) ? row_cur : row_cur + RW'(1);
   assign col_in   = wrap1 ? '0 : col_next[CW-1:0];
   assign row_in   = wrap1 ? row_inc1 : row_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // position of the current item
   assign col             = col_cur;
   assign row             = row_cur;
   assign right_addr      = wrap1 ? col_cur : col_next[CW-1:0];
   assign flags.first_col = (col_cur == '0);
   assign flags.right_ok  = !wrap1;
   assign flags.has_out   = (row_cur != '0);

endmodule

[hdl/four_neighbor_autotile.sv]
// ----------------------------------------------------------------------------
// four_neighbor_autotile
// Streaming 4-neighbor bitmask autotiler built around two line RAMs.
// ----------------------------------------------------------------------------
// Usage:
//  - req stream: one map tile per item in raster order; tdata holds tile_id,
//    tuser marks pad items and the first tile of a map. Send one row of pad
//    items after the last map row to flush it.
//  - rsp stream: one item per tile of the map, trailing its input by one
//    row: the result for a tile goes out when the tile below it comes in.
//  - csr port: row_width at byte address 0, written while the block is idle.
//  - throughput: one item per cycle outside clearing and output stalls;
//    each item reads the line RAMs when accepted and writes them back as
//    it leaves the read stage, with forwarding from the item ahead.
//  - result path: the item that completes a neighborhood is registered in
//    the read stage, and its result then in the output register on rsp.
//  - reset: a clearing pass zeroes the line RAMs, one entry per cycle over
//    all MAX_WIDTH entries, with req_tready low; register writes still go in.
//  - stall: a full output register with rsp_tready low holds the item in
//    the read stage and drops req_tready; nothing is lost.
// ----------------------------------------------------------------------------
module four_neighbor_autotile #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_ROWS  = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   // tile items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [fna_pkg::REQ_DATA_W-1:0]      req_tdata,   // [15:0] tile_id
   input  logic [fna_pkg::REQ_USER_W-1:0]      req_tuser,   // [0] pad, [1] start_of_map
   // result items
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fna_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [4:0] new_tile,
                                                            // [14:5] out_col,
                                                            // [26:15] out_row
   // registers
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fna_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [fna_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [fna_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import fna_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_ROWS);
   localparam logic [CW-1:0] CLR_LAST = CW'(MAX_WIDTH - 1);

   logic [ROW_WIDTH_W-1:0] row_width;
   logic                   accept;
   logic                   solid;
   logic [CW-1:0]          ix_col, ix_right;
   logic [RW-1:0]          ix_row;
   fna_flags_type          ix_flags;

   // read stage
   logic                   s1_valid_ff, s1_valid_in;
   logic [CW-1:0]          s1_col_ff;
   logic [RW-1:0]          s1_row_ff;
   logic                   s1_solid_ff;
   fna_flags_type          s1_flags_ff;
   logic                   s1_fwd_up_ff, s1_fwd_mid_ff, s1_fwd_rt_ff;
   logic                   s1_fv_up_ff, s1_fv_solid_ff;
   logic                   s1_adv, s1_leave;
   logic                   left_ff;

   // line RAM ports
   logic [1:0]             ram_line;   // [0] center, [1] above
   logic                   ram_up, ram_mid, ram_rt;
   logic                   wr_en;
   logic [CW-1:0]          wr_addr;
   logic                   wr_above, wr_center;

   // clearing pass
   logic                   clr_ff, clr_in;
   logic [CW-1:0]          clr_addr_ff, clr_addr_in;

   // result
   logic                   up, mid, rt, left;
   logic [3:0]             mask;
   logic [NEW_TILE_W-1:0]  new_tile;
   logic [RW-1:0]          row_m1;
   logic [RW+OUT_ROW_W-1:0] row_ext;
   logic [CW+OUT_COL_W-1:0] col_ext;
   logic                   out_valid_ff, out_valid_in;
   logic [NEW_TILE_W-1:0]  out_tile_ff;
   logic [OUT_COL_W-1:0]   out_col_ff;
   logic [OUT_ROW_W-1:0]   out_row_ff;

   fna_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .row_width   (row_width)
   );

   // input handshake
   assign s1_adv     = !out_valid_ff || rsp_tready;
   assign s1_leave   = s1_valid_ff && s1_adv;
   assign req_tready = !clr_ff && (!s1_valid_ff || s1_adv);
   assign accept     = req_tvalid && req_tready;
   assign solid      = (req_tdata[TILE_ID_W-1:0] != '0) && !req_tuser[USER_PAD];

   fna_index #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_ROWS  (MAX_ROWS)
   ) u_index (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .start_of_map (req_tuser[USER_START]),
      .row_width    (row_width),
      .col          (ix_col),
      .right_addr   (ix_right),
      .row          (ix_row),
      .flags        (ix_flags)
   );

   // line RAMs: above and center rows at the column, center row to its right
   fna_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({wr_above, wr_center}),
      .rd_en   (accept),
      .rd_addr (ix_col),
      .rd_data (ram_line)
   );

   assign ram_up  = ram_line[1];
   assign ram_mid = ram_line[0];

   fna_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_right_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_center),
      .rd_en   (accept),
      .rd_addr (ix_right),
      .rd_data (ram_rt)
   );

   // clearing pass after reset
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + CW'(1);
         if (clr_addr_ff == CLR_LAST) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // neighbor bits, forwarded from the item written back at the read edge
   assign up   = s1_fwd_up_ff  ? s1_fv_up_ff    : ram_up;
   assign mid  = s1_fwd_mid_ff ? s1_fv_solid_ff : ram_mid;
   assign rt   = s1_flags_ff.right_ok && (s1_fwd_rt_ff ? s1_fv_solid_ff : ram_rt);
   assign left = !s1_flags_ff.first_col && left_ff;
   assign mask = {s1_solid_ff, rt, left, up};
   assign new_tile = mid ? ({1'b0, mask} + NEW_TILE_W'(1)) : '0;

   // write back
   assign wr_en     = clr_ff || s1_leave;
   assign wr_addr   = clr_ff ? clr_addr_ff : s1_col_ff;
   assign wr_above  = !clr_ff && s1_flags_ff.has_out && mid;
   assign wr_center = !clr_ff && s1_solid_ff;

   // read stage register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff      <= ix_col;
         s1_row_ff      <= ix_row;
         s1_solid_ff    <= solid;
         s1_flags_ff    <= ix_flags;
         s1_fwd_up_ff   <= s1_valid_ff && (ix_col == s1_col_ff);
         s1_fwd_mid_ff  <= s1_valid_ff && (ix_col == s1_col_ff);
         s1_fwd_rt_ff   <= s1_valid_ff && (ix_right == s1_col_ff);
         s1_fv_up_ff    <= wr_above;
         s1_fv_solid_ff <= s1_solid_ff;
      end
   end

   // left neighbor is the center bit of the previous item
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 1'b0;
      end else if (s1_leave) begin
         left_ff <= mid;
      end
   end

   // output register
   assign row_m1  = s1_row_ff - RW'(1);
   assign row_ext = {{OUT_ROW_W{1'b0}}, row_m1};
   assign col_ext = {{OUT_COL_W{1'b0}}, s1_col_ff};

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_leave && s1_flags_ff.has_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_leave && s1_flags_ff.has_out) begin
         out_tile_ff <= new_tile;
         out_col_ff  <= col_ext[OUT_COL_W-1:0];
         out_row_ff  <= row_ext[OUT_ROW_W-1:0];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-NEW_TILE_W-OUT_COL_W-OUT_ROW_W){1'b0}},
                        out_row_ff, out_col_ff, out_tile_ff};

endmodule

[hdl/fna_checker.sv]
// ----------------------------------------------------------------------------
// fna_checker
// Port-level checks of the autotiler: output hold, clearing after reset and
// the minimum path from an accepted item to a new result.
// ----------------------------------------------------------------------------
module fna_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [fna_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import fna_pkg::*;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // the line clearing pass blocks input right after reset
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("input taken during line clearing");

   // a new result needs an item accepted ahead of it
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result item without a source item");

   // nothing goes out while lines are still being cleared
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result item during line clearing");

endmodule

bind four_neighbor_autotile fna_checker u_fna_checker (.*);
